/* sv/k2g_pkg.sv */
// Shared types, codes and the default mapping layout of the key-to-gamepad mapper.
package k2g_pkg;

	// Item kinds carried on the slave tuser
	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_SYNC  = 2'd1;
	localparam logic [1:0] KIND_ENTRY = 2'd2;

	// Key values
	localparam logic [1:0] KEY_RELEASED = 2'd0;
	localparam logic [1:0] KEY_REPEAT   = 2'd2;

	// Event classes carried on the master tuser
	localparam logic [1:0] CLS_BUTTON = 2'd0;
	localparam logic [1:0] CLS_AXIS   = 2'd1;
	localparam logic [1:0] CLS_SYNC   = 2'd2;

	// Axis sign codes, two bits per axis
	localparam logic [1:0] SGN_CENTRE = 2'd0;
	localparam logic [1:0] SGN_POS    = 2'd1;
	localparam logic [1:0] SGN_NEG    = 2'd2;

	localparam logic [14:0] FULL_SCALE_RESET = 15'd512;

	// Bit layout matches the packed slot: key lowest, valid highest
	typedef struct packed {
		logic       valid;
		logic       neg;
		logic [9:0] target;
		logic       btn;
		logic [2:0] pad;
		logic [9:0] key;
	} map_entry_t;

	typedef struct packed {
		logic [2:0]         pad;
		logic [1:0]         cls;
		logic [9:0]         code;
		logic signed [15:0] value;
	} evt_t;

	typedef struct packed {
		logic       upd;
		logic       emit;
		logic [3:0] held;
		logic [3:0] sign;
		evt_t       evt;
	} eval_res_t;

	typedef struct packed {
		logic put;
		logic finish;
	} buf_ctl_t;

	typedef struct packed {
		logic put_ready;
		logic finish_done;
	} buf_st_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SYNC,
		ST_FLUSH
	} state_t;

	function automatic map_entry_t mk_entry(input logic [9:0] key, input logic [2:0] pad,
			input logic btn, input logic [9:0] target, input logic neg);
		map_entry_t e;
		e.valid  = 1'b1;
		e.neg    = neg;
		e.target = target;
		e.btn    = btn;
		e.pad    = pad;
		e.key    = key;
		return e;
	endfunction

	// Power-on layout: pad 0 on letter keys, pad 1 on the navigation cluster
	function automatic map_entry_t default_entry(input logic [7:0] idx);
		map_entry_t e;
		unique case (idx)
			8'd0: begin e = mk_entry(10'd17, 3'd0, 1'b0, 10'd1, 1'b1); end
			8'd1: begin e = mk_entry(10'd31, 3'd0, 1'b0, 10'd1, 1'b0); end
			8'd2: begin e = mk_entry(10'd30, 3'd0, 1'b0, 10'd0, 1'b1); end
			8'd3: begin e = mk_entry(10'd32, 3'd0, 1'b0, 10'd0, 1'b0); end
			8'd4: begin e = mk_entry(10'd34, 3'd0, 1'b1, 10'd304, 1'b0); end
			8'd5: begin e = mk_entry(10'd35, 3'd0, 1'b1, 10'd305, 1'b0); end
			8'd6: begin e = mk_entry(10'd20, 3'd0, 1'b1, 10'd307, 1'b0); end
			8'd7: begin e = mk_entry(10'd33, 3'd0, 1'b1, 10'd308, 1'b0); end
			8'd8: begin e = mk_entry(10'd103, 3'd1, 1'b0, 10'd1, 1'b1); end
			8'd9: begin e = mk_entry(10'd108, 3'd1, 1'b0, 10'd1, 1'b0); end
			8'd10: begin e = mk_entry(10'd105, 3'd1, 1'b0, 10'd0, 1'b1); end
			8'd11: begin e = mk_entry(10'd106, 3'd1, 1'b0, 10'd0, 1'b0); end
			8'd12: begin e = mk_entry(10'd107, 3'd1, 1'b1, 10'd304, 1'b0); end
			8'd13: begin e = mk_entry(10'd104, 3'd1, 1'b1, 10'd305, 1'b0); end
			8'd14: begin e = mk_entry(10'd70, 3'd1, 1'b1, 10'd307, 1'b0); end
			8'd15: begin e = mk_entry(10'd110, 3'd1, 1'b1, 10'd308, 1'b0); end
			8'd16: begin e = mk_entry(10'd102, 3'd1, 1'b1, 10'd315, 1'b0); end
			default: begin e = '0; end
		endcase
		return e;
	endfunction

endpackage

/* sv/k2g_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module k2g_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/k2g_entry_unit.sv */
// Shared evaluation unit: matches one table entry and works out its event and axis update.
module k2g_entry_unit #(
	parameter int PADS = 8
) (
	input  k2g_pkg::map_entry_t entry,
	input  logic [9:0]          key,
	input  logic                pressed,
	input  logic [3:0]          held,
	input  logic [3:0]          sign,
	input  logic [14:0]         full_scale,
	output k2g_pkg::eval_res_t  res
);
	import k2g_pkg::*;

	logic        hit;
	logic        axis;
	logic [1:0]  bit_sel;
	logic [3:0]  new_held;
	logic [1:0]  pair;
	logic [1:0]  new_s;
	logic [1:0]  old_s;
	logic [15:0] fs16;
	logic [15:0] axis_val;

	always_comb begin
		hit  = entry.valid && (entry.key == key) && (int'(entry.pad) < PADS);
		axis = (entry.target != 10'd0);

		// Low bit of each pair is the negative direction
		bit_sel           = {axis, ~entry.neg};
		new_held          = held;
		new_held[bit_sel] = pressed;
		pair              = axis ? new_held[3:2] : new_held[1:0];

		if (pair == 2'b10) begin
			new_s = SGN_POS;
		end else if (pair == 2'b01) begin
			new_s = SGN_NEG;
		end else begin
			new_s = SGN_CENTRE;
		end
		old_s = axis ? sign[3:2] : sign[1:0];

		fs16 = {1'b0, full_scale};
		if (new_s == SGN_POS) begin
			axis_val = fs16;
		end else if (new_s == SGN_NEG) begin
			axis_val = ~fs16 + 16'd1;
		end else begin
			axis_val = 16'd0;
		end

		res.upd  = hit && !entry.btn;
		res.emit = hit && (entry.btn || (new_s != old_s));
		res.held = new_held;
		res.sign = axis ? {new_s, sign[1:0]} : {sign[3:2], new_s};

		res.evt.pad = entry.pad;
		if (entry.btn) begin
			res.evt.cls   = CLS_BUTTON;
			res.evt.code  = entry.target;
			res.evt.value = {15'd0, pressed};
		end else begin
			res.evt.cls   = CLS_AXIS;
			res.evt.code  = {9'd0, axis};
			res.evt.value = axis_val;
		end
	end

endmodule

/* sv/k2g_result_buf.sv */
// Result buffer: one pending slot that waits for its successor, then the output register.
module k2g_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  k2g_pkg::buf_ctl_t ctl,
	input  k2g_pkg::evt_t     evt,
	output k2g_pkg::buf_st_t  st,
	input  logic              m_tready,
	output logic              m_tvalid,
	output k2g_pkg::evt_t     m_evt,
	output logic              m_last
);
	import k2g_pkg::*;

	logic pend_v_q;
	evt_t pend_q;
	logic out_v_q;
	evt_t out_q;
	logic last_q;
	logic out_free;

	assign out_free       = !out_v_q || m_tready;
	assign st.put_ready   = !pend_v_q || out_free;
	assign st.finish_done = !pend_v_q || out_free;

	assign m_tvalid = out_v_q;
	assign m_evt    = out_q;
	assign m_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.put && st.put_ready) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end else if (m_tready) begin
					out_v_q <= 1'b0;
				end
			end else if (ctl.finish && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload: no reset
	always_ff @(posedge clk) begin
		if (ctl.put && st.put_ready) begin
			pend_q <= evt;
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
		end else if (ctl.finish && pend_v_q && out_free) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

`ifndef SYNTH
	// A put never lands while the pending beat cannot move on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && out_v_q && !m_tready) |=> $stable(pend_q))
		else $error("pending beat overwritten");
	// The last beat of a run leaves the pending slot empty
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && pend_v_q && out_free && !ctl.put) |=> (!pend_v_q && out_v_q && m_last))
		else $error("final beat not presented");
`endif

endmodule

/* sv/key_to_gamepad_event_mapper.sv */
// Top level of the key-to-gamepad event mapper: sequencer, pad state and register port.
// A key event scans the table one entry per cycle while the result buffer can take its
// events, then flushes; a new item is taken only once the block is back in idle. A sync
// item walks the pads, one per cycle while the buffer can take their reports, then flushes.
// Entry writes, auto-repeat and unused kinds leave the block in idle. The first result
// appears in the cycle after the second event is placed in the buffer, or in the cycle
// after the flush. Reset (arst_n low) restores the default layout through per-entry
// written flags at once, clears pad state, full scale 512.
module key_to_gamepad_event_mapper #(
	parameter int MAP_ENTRIES = 32,
	parameter int PADS        = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// key_code[9:0], key_value[11:10], entry_index[16:12], entry_key[26:17],
	// entry_pad[29:27], entry_is_button[30], entry_target[40:31],
	// entry_negative[41], entry_valid[42], zero fill [47:43]
	input  logic [47:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// pad_index[2:0], event_code[12:3], event_value[28:13], zero fill [31:29]
	output logic [31:0] m_tdata,
	// event_class[1:0]
	output logic [1:0]  m_tuser,
	// last_of_run
	output logic        m_tlast,
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import k2g_pkg::*;

	localparam int AW  = $clog2(MAP_ENTRIES);
	localparam int PIW = (PADS > 1) ? $clog2(PADS) : 1;
	localparam logic REG_AXIS_FULL_SCALE = 1'b0;

	// Unpacked input beat
	logic [9:0] key_code;
	logic [1:0] key_value;
	logic [4:0] entry_index;
	map_entry_t wr_entry;

	assign key_code        = s_tdata[9:0];
	assign key_value       = s_tdata[11:10];
	assign entry_index     = s_tdata[16:12];
	assign wr_entry.key    = s_tdata[26:17];
	assign wr_entry.pad    = s_tdata[29:27];
	assign wr_entry.btn    = s_tdata[30];
	assign wr_entry.target = s_tdata[40:31];
	assign wr_entry.neg    = s_tdata[41];
	assign wr_entry.valid  = s_tdata[42];

	state_t state_q, state_d;

	logic [AW-1:0]          scan_idx_q;
	logic [PIW-1:0]         sync_q;
	logic [9:0]             key_q;
	logic                   pressed_q;
	logic [14:0]            fs_q;
	logic [3:0]             held_q [PADS];
	logic [3:0]             sign_q [PADS];
	logic [PADS-1:0]        dirty_q;
	logic [MAP_ENTRIES-1:0] written_q;

	logic                   accept;
	logic                   wr_en;
	logic [AW-1:0]          raddr;
	logic [$bits(map_entry_t)-1:0] ram_rdata;
	map_entry_t             scan_entry;
	logic                   pad_ok;
	logic [PIW-1:0]         pidx;
	logic [3:0]             cur_held;
	logic [3:0]             cur_sign;
	eval_res_t              res;
	logic                   advance;
	buf_ctl_t               buf_ctl;
	buf_st_t                buf_st;
	evt_t                   put_evt;
	evt_t                   m_evt;
	logic                   cfg_wr;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && (s_tuser == KIND_ENTRY) && (int'(entry_index) < MAP_ENTRIES);

	// Register port: one register, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_AXIS_FULL_SCALE);
	assign prdata = (paddr[2] == REG_AXIS_FULL_SCALE) ? {17'd0, fs_q} : 32'd0;

	k2g_ram #(
		.WIDTH($bits(map_entry_t)),
		.DEPTH(MAP_ENTRIES)
	) u_map_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(AW'(entry_index)),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Untouched entries read as the power-on layout
	assign scan_entry = written_q[scan_idx_q] ? map_entry_t'(ram_rdata)
	                                          : default_entry(8'(scan_idx_q));

	// Pads beyond range never match; keep their reads tidy
	assign pad_ok   = (int'(scan_entry.pad) < PADS);
	assign pidx     = PIW'(scan_entry.pad);
	assign cur_held = pad_ok ? held_q[pidx] : 4'd0;
	assign cur_sign = pad_ok ? sign_q[pidx] : 4'd0;

	k2g_entry_unit #(
		.PADS(PADS)
	) u_entry_unit (
		.entry     (scan_entry),
		.key       (key_q),
		.pressed   (pressed_q),
		.held      (cur_held),
		.sign      (cur_sign),
		.full_scale(fs_q),
		.res       (res)
	);

	k2g_result_buf u_result_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (buf_ctl),
		.evt     (put_evt),
		.st      (buf_st),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_evt   (m_evt),
		.m_last  (m_tlast)
	);

	assign m_tdata = {3'd0, m_evt.value, m_evt.code, m_evt.pad};
	assign m_tuser = m_evt.cls;

	// Sequencer: next state, buffer control and table read address
	always_comb begin
		state_d        = state_q;
		advance        = 1'b0;
		buf_ctl.put    = 1'b0;
		buf_ctl.finish = 1'b0;
		put_evt        = res.evt;
		raddr          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (s_tuser == KIND_KEY) && (key_value != KEY_REPEAT)) begin
					state_d = ST_SCAN;
				end else if (accept && (s_tuser == KIND_SYNC)) begin
					state_d = ST_SYNC;
				end
			end
			ST_SCAN: begin
				buf_ctl.put = res.emit;
				advance     = !res.emit || buf_st.put_ready;
				if (!advance) begin
					raddr = scan_idx_q;
				end else if (scan_idx_q == AW'(MAP_ENTRIES - 1)) begin
					state_d = ST_FLUSH;
				end else begin
					raddr = scan_idx_q + AW'(1);
				end
			end
			ST_SYNC: begin
				put_evt.pad   = 3'(sync_q);
				put_evt.cls   = CLS_SYNC;
				put_evt.code  = 10'd0;
				put_evt.value = 16'sd0;
				buf_ctl.put   = dirty_q[sync_q];
				advance       = !dirty_q[sync_q] || buf_st.put_ready;
				if (advance && (sync_q == PIW'(PADS - 1))) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				buf_ctl.finish = 1'b1;
				if (buf_st.finish_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan and sync counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			sync_q     <= '0;
		end else begin
			if (accept) begin
				scan_idx_q <= '0;
				sync_q     <= '0;
			end else if (advance && (state_q == ST_SCAN)) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end else if (advance && (state_q == ST_SYNC)) begin
				sync_q <= sync_q + PIW'(1);
			end
		end
	end

	// Hold the key of the event under scan; any nonzero value counts as pressed
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= key_code;
			pressed_q <= (key_value != KEY_RELEASED);
		end
	end

	// Pad state: held directions, axis signs, dirty marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PADS; p++) begin
				held_q[p] <= 4'd0;
				sign_q[p] <= 4'd0;
			end
			dirty_q <= '0;
		end else begin
			if ((state_q == ST_SCAN) && advance) begin
				if (res.upd) begin
					held_q[pidx] <= res.held;
					sign_q[pidx] <= res.sign;
				end
				if (res.emit) begin
					dirty_q[pidx] <= 1'b1;
				end
			end else if ((state_q == ST_SYNC) && advance) begin
				// Drop the mark once its report is in the buffer
				dirty_q[sync_q] <= 1'b0;
			end
		end
	end

	// Written flags and the full-scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			fs_q      <= FULL_SCALE_RESET;
		end else begin
			if (wr_en) begin
				written_q[AW'(entry_index)] <= 1'b1;
			end
			if (cfg_wr) begin
				fs_q <= pwdata[14:0];
			end
		end
	end

`ifndef SYNTH
	// A key event that is not auto-repeat starts a table scan
	a_key_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == KIND_KEY) && (key_value != KEY_REPEAT)) |=>
		(state_q == ST_SCAN) && (scan_idx_q == '0))
		else $error("key event did not start a scan");
	// Any event placed during a scan leaves at least one pad dirty
	a_emit_marks_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && buf_ctl.put && buf_st.put_ready) |=> (dirty_q != '0))
		else $error("emitted event left no pad dirty");
	// Axis sign of pad 0 is never the unused code
	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		(sign_q[0][1:0] != 2'd3) && (sign_q[0][3:2] != 2'd3))
		else $error("illegal axis sign code");
	// A finished sync leaves no pad dirty
	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SYNC) && (state_d == ST_FLUSH)) |=> (dirty_q == '0))
		else $error("dirty mark survived sync");
`endif

endmodule
